/* hw/rtl/aavr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aavr_pkg
// Beat types, angle constants and the arctangent table for the axis-angle
// vector rotator.
// ----------------------------------------------------------------------------
package aavr_pkg;

  // input beat: vector and axis in q16.16, angle in q4.28 radians
  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] turn_angle;
  } rot_in_t;

  // output beat: rotated vector in q16.16, saturated
  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
  } rot_out_t;

  // angle constants in q.30
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [71:0] Q30_ONE     = 72'sd1073741824;
  localparam int unsigned        CORDIC_STEPS = 30;

  // floor(atan(2^-i) * 2^30)
  function automatic logic signed [34:0] atan_q30(input logic [4:0] idx);
    logic signed [34:0] val;
    case (idx)
      5'd0:  val = 35'sd843314856;
      5'd1:  val = 35'sd497837829;
      5'd2:  val = 35'sd263043836;
      5'd3:  val = 35'sd133525158;
      5'd4:  val = 35'sd67021686;
      5'd5:  val = 35'sd33543515;
      5'd6:  val = 35'sd16775850;
      5'd7:  val = 35'sd8388437;
      5'd8:  val = 35'sd4194282;
      5'd9:  val = 35'sd2097149;
      5'd10: val = 35'sd1048575;
      5'd11: val = 35'sd524287;
      5'd12: val = 35'sd262143;
      5'd13: val = 35'sd131071;
      5'd14: val = 35'sd65535;
      5'd15: val = 35'sd32767;
      5'd16: val = 35'sd16383;
      5'd17: val = 35'sd8191;
      5'd18: val = 35'sd4095;
      5'd19: val = 35'sd2047;
      5'd20: val = 35'sd1023;
      5'd21: val = 35'sd511;
      5'd22: val = 35'sd255;
      5'd23: val = 35'sd127;
      5'd24: val = 35'sd63;
      5'd25: val = 35'sd31;
      5'd26: val = 35'sd15;
      5'd27: val = 35'sd7;
      5'd28: val = 35'sd3;
      5'd29: val = 35'sd1;
      default: val = 35'sd0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/axis_angle_vector_rotate.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate
// Rotates a q16.16 vector about an arbitrary axis by a q4.28 angle using
// the Rodrigues formula, fully pipelined at one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
// One beat enters per clock while the output is not held, and its result
// leaves after the chain of register stages: two for axis scaling and angle
// reduction, one for the squares, one for their sum, sixteen for the square
// root (two root bits a stage), sixteen for the three parallel dividers (two
// quotient bits a stage), one to sign the unit axis and six for the multiply
// and rescale steps of the formula. Sine and cosine come from a 30-step
// cordic that runs two steps a stage beside the square root. Valid bits
// travel with every stage; when a finished beat waits at the output, the
// whole pipe holds, so nothing is lost or repeated. A zero axis gives v*cos.
// COMP_WIDTH (16..32) sets the range that inputs are sign-extended from and
// results saturate to.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotate
  import aavr_pkg::*;
#(
  parameter int unsigned COMP_WIDTH = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire rot_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output rot_out_t      out_data_o
);

  // stage map
  localparam int unsigned ST_SQUARE = 2;
  localparam int unsigned ST_SUM    = 3;
  localparam int unsigned ST_SQRT0  = 4;
  localparam int unsigned ST_SQRT1  = 19;
  localparam int unsigned ST_DIV0   = 20;
  localparam int unsigned ST_DIV1   = 35;
  localparam int unsigned ST_UNIT   = 36;
  localparam int unsigned ST_MUL_A  = 37;
  localparam int unsigned ST_SCALE  = 38;
  localparam int unsigned ST_MUL_B  = 39;
  localparam int unsigned ST_TRUNC  = 40;
  localparam int unsigned ST_MUL_C  = 41;
  localparam int unsigned ST_OUT    = 42;
  localparam int unsigned NST       = 43;
  localparam int unsigned CORD0     = 2;
  localparam int unsigned CORD1     = 16;
  localparam int unsigned ST_CSIGN  = 17;
  localparam int unsigned QBITS     = 31;

  // component range
  localparam int unsigned       SH     = 32 - COMP_WIDTH;
  localparam logic signed [39:0] SAT_HI = (40'sd1 <<< (COMP_WIDTH - 1)) - 40'sd1;
  localparam logic signed [39:0] SAT_LO = -SAT_HI - 40'sd1;
  localparam logic [31:0]        MASK   = {32{1'b1}} >> SH;

  typedef struct packed {
    logic [2:0][31:0]   vec;    // sign-extended vector
    logic [2:0][31:0]   ua;     // axis magnitudes, later normalized
    logic [2:0]         asgn;   // axis signs
    logic [31:0]        amax;
    logic               azero;
    logic [2:0][63:0]   sq;
    logic [63:0]        nrad;   // radicand, consumed two bits a step
    logic [33:0]        srem;
    logic [31:0]        root;
    logic [2:0][32:0]   drem;
    logic [2:0][30:0]   quo;
    logic signed [34:0] ang;    // cordic residual angle
    logic               neg;
    logic signed [33:0] cx;     // cos
    logic signed [33:0] cy;     // sin
    logic [2:0][31:0]   kv;     // unit axis q2.30
    logic [8:0][63:0]   pk;
    logic [2:0][65:0]   pc;
    logic [35:0]        dq;
    logic [2:0][35:0]   cp;
    logic [2:0][35:0]   t1;
    logic [32:0]        omc;
    logic [2:0][71:0]   pp;
    logic [2:0][71:0]   p3;
    logic [2:0][35:0]   proj;
    logic [2:0][35:0]   t3;
    logic [2:0][71:0]   p2;
    logic [2:0][31:0]   res;
  } stage_t;

  // division by 2^n truncating toward zero
  function automatic logic signed [71:0] tdiv(input logic signed [71:0] x,
                                              input int unsigned n);
    logic signed [71:0] bias;
    bias = x[71] ? ((72'sd1 <<< n) - 72'sd1) : 72'sd0;
    return (x + bias) >>> n;
  endfunction

  function automatic logic signed [71:0] smul(input logic signed [35:0] a,
                                              input logic signed [35:0] b);
    logic signed [71:0] p;
    p = a * b;
    return p;
  endfunction

  logic [NST-1:0] valid_q;
  stage_t         pipe_q [NST];
  stage_t         pipe_d [NST];
  logic           en;

  // the whole pipe advances unless a finished beat is held at the output
  assign en          = !valid_q[NST-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[NST-1];

  assign out_data_o.rot_x = pipe_q[NST-1].res[0];
  assign out_data_o.rot_y = pipe_q[NST-1].res[1];
  assign out_data_o.rot_z = pipe_q[NST-1].res[2];

  // stage 0: sign-extend, axis magnitudes, first angle reduction
  logic [2:0][31:0] vin;
  logic [2:0][31:0] ain;
  stage_t           s0;
  assign vin = {in_data_i.vec_z, in_data_i.vec_y, in_data_i.vec_x};
  assign ain = {in_data_i.axis_z, in_data_i.axis_y, in_data_i.axis_x};

  always_comb begin
    logic [31:0]        sh_t;
    logic signed [31:0] a_s;
    logic signed [34:0] a4;
    s0 = '0;
    for (int i = 0; i < 3; i++) begin
      sh_t       = vin[i] << SH;
      s0.vec[i]  = 32'($signed(sh_t) >>> SH);
      sh_t       = ain[i] << SH;
      a_s        = $signed(sh_t) >>> SH;
      s0.asgn[i] = a_s[31];
      s0.ua[i]   = a_s[31] ? 32'(-a_s) : 32'(a_s);
    end
    s0.amax = s0.ua[0];
    if (s0.ua[1] > s0.amax) s0.amax = s0.ua[1];
    if (s0.ua[2] > s0.amax) s0.amax = s0.ua[2];
    // angle to q.30, remainder by 2*pi (at most one turn off)
    a4 = 35'($signed(in_data_i.turn_angle)) <<< 2;
    if (a4 >= TWO_PI_Q30) begin
      a4 = a4 - TWO_PI_Q30;
    end else if (a4 <= -TWO_PI_Q30) begin
      a4 = a4 + TWO_PI_Q30;
    end
    s0.ang = a4;
  end

  assign pipe_d[0] = s0;

  for (genvar j = 1; j < NST; j++) begin : g_stage
    stage_t nx;

    always_comb begin
      int unsigned        msb;
      logic [4:0]         sh;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] xs;
      logic signed [33:0] ys;
      logic [33:0]        rem2;
      logic [33:0]        trial;
      logic               ge;
      int unsigned        it;
      logic signed [71:0] acc;
      logic signed [39:0] t2;
      logic signed [39:0] sum;
      nx    = pipe_q[j-1];
      msb   = 0;
      sh    = '0;
      x     = '0;
      y     = '0;
      xs    = '0;
      ys    = '0;
      rem2  = '0;
      trial = '0;
      ge    = 1'b0;
      it    = 0;
      acc   = '0;
      t2    = '0;
      sum   = '0;

      // axis scaling so the largest magnitude reaches 2^30; angle fold
      if (j == 1) begin
        for (int k = 0; k < 32; k++) begin
          if (nx.amax[k]) msb = k;
        end
        if (nx.amax[31] || nx.amax[30]) begin
          sh = '0;
        end else begin
          sh = 5'(30 - msb);
        end
        nx.azero = (nx.amax == '0);
        for (int i = 0; i < 3; i++) begin
          nx.ua[i] = nx.ua[i] << sh;
        end
        if (nx.ang > PI_Q30) begin
          nx.ang = nx.ang - TWO_PI_Q30;
        end else if (nx.ang < -PI_Q30) begin
          nx.ang = nx.ang + TWO_PI_Q30;
        end
        nx.neg = 1'b0;
        if (nx.ang > HALF_PI_Q30) begin
          nx.ang = nx.ang - PI_Q30;
          nx.neg = 1'b1;
        end else if (nx.ang < -HALF_PI_Q30) begin
          nx.ang = nx.ang + PI_Q30;
          nx.neg = 1'b1;
        end
      end

      // cordic, two steps a stage
      if (j >= CORD0 && j <= CORD1) begin
        if (j == CORD0) begin
          x = CORDIC_GAIN;
          y = '0;
        end else begin
          x = nx.cx;
          y = nx.cy;
        end
        for (int b = 0; b < 2; b++) begin
          it = 2 * (j - CORD0) + b;
          xs = 34'(tdiv(72'(y), it));
          ys = 34'(tdiv(72'(x), it));
          if (nx.ang >= 0) begin
            x      = x - xs;
            y      = y + ys;
            nx.ang = nx.ang - atan_q30(5'(it));
          end else begin
            x      = x + xs;
            y      = y - ys;
            nx.ang = nx.ang + atan_q30(5'(it));
          end
        end
        nx.cx = x;
        nx.cy = y;
      end
      if (j == ST_CSIGN && nx.neg) begin
        nx.cx = -nx.cx;
        nx.cy = -nx.cy;
      end

      if (j == ST_SQUARE) begin
        for (int i = 0; i < 3; i++) begin
          nx.sq[i] = 64'(nx.ua[i]) * 64'(nx.ua[i]);
        end
      end
      if (j == ST_SUM) begin
        nx.nrad = nx.sq[0] + nx.sq[1] + nx.sq[2];
      end

      // floor square root, two root bits a stage
      if (j >= ST_SQRT0 && j <= ST_SQRT1) begin
        if (j == ST_SQRT0) begin
          nx.srem = '0;
          nx.root = '0;
        end
        for (int b = 0; b < 2; b++) begin
          rem2    = {nx.srem[31:0], nx.nrad[63:62]};
          trial   = {nx.root, 2'b01};
          nx.nrad = nx.nrad << 2;
          if (rem2 >= trial) begin
            nx.srem = rem2 - trial;
            nx.root = {nx.root[30:0], 1'b1};
          end else begin
            nx.srem = rem2;
            nx.root = {nx.root[30:0], 1'b0};
          end
        end
      end

      // restoring divide ua * 2^30 / len, three lanes, two bits a stage
      if (j >= ST_DIV0 && j <= ST_DIV1) begin
        if (j == ST_DIV0) begin
          for (int i = 0; i < 3; i++) begin
            nx.drem[i] = {1'b0, nx.ua[i]};
          end
        end
        for (int b = 0; b < 2; b++) begin
          it = 2 * (j - ST_DIV0) + b;
          if (it < QBITS) begin
            for (int i = 0; i < 3; i++) begin
              ge = nx.drem[i] >= {1'b0, nx.root};
              if (ge) nx.drem[i] = nx.drem[i] - {1'b0, nx.root};
              nx.quo[i]  = {nx.quo[i][29:0], ge};
              nx.drem[i] = {nx.drem[i][31:0], 1'b0};
            end
          end
        end
      end

      if (j == ST_UNIT) begin
        for (int i = 0; i < 3; i++) begin
          if (nx.azero) begin
            nx.kv[i] = '0;
          end else if (nx.asgn[i]) begin
            nx.kv[i] = -{1'b0, nx.quo[i]};
          end else begin
            nx.kv[i] = {1'b0, nx.quo[i]};
          end
        end
      end

      // dot, cross and v*cos products
      if (j == ST_MUL_A) begin
        nx.pk[0] = 64'(smul(36'($signed(nx.kv[0])), 36'($signed(nx.vec[0]))));
        nx.pk[1] = 64'(smul(36'($signed(nx.kv[1])), 36'($signed(nx.vec[1]))));
        nx.pk[2] = 64'(smul(36'($signed(nx.kv[2])), 36'($signed(nx.vec[2]))));
        nx.pk[3] = 64'(smul(36'($signed(nx.kv[1])), 36'($signed(nx.vec[2]))));
        nx.pk[4] = 64'(smul(36'($signed(nx.kv[2])), 36'($signed(nx.vec[1]))));
        nx.pk[5] = 64'(smul(36'($signed(nx.kv[2])), 36'($signed(nx.vec[0]))));
        nx.pk[6] = 64'(smul(36'($signed(nx.kv[0])), 36'($signed(nx.vec[2]))));
        nx.pk[7] = 64'(smul(36'($signed(nx.kv[0])), 36'($signed(nx.vec[1]))));
        nx.pk[8] = 64'(smul(36'($signed(nx.kv[1])), 36'($signed(nx.vec[0]))));
        for (int i = 0; i < 3; i++) begin
          nx.pc[i] = 66'(smul(36'($signed(nx.vec[i])), 36'(nx.cx)));
        end
      end

      if (j == ST_SCALE) begin
        acc   = 72'($signed(nx.pk[0])) + 72'($signed(nx.pk[1])) +
                72'($signed(nx.pk[2]));
        nx.dq = 36'(tdiv(acc, 30));
        acc   = 72'($signed(nx.pk[3])) - 72'($signed(nx.pk[4]));
        nx.cp[0] = 36'(tdiv(acc, 30));
        acc   = 72'($signed(nx.pk[5])) - 72'($signed(nx.pk[6]));
        nx.cp[1] = 36'(tdiv(acc, 30));
        acc   = 72'($signed(nx.pk[7])) - 72'($signed(nx.pk[8]));
        nx.cp[2] = 36'(tdiv(acc, 30));
        for (int i = 0; i < 3; i++) begin
          nx.t1[i] = 36'(tdiv(72'($signed(nx.pc[i])), 30));
        end
        nx.omc = 33'(tdiv(Q30_ONE - 72'(nx.cx), 1));
      end

      if (j == ST_MUL_B) begin
        for (int i = 0; i < 3; i++) begin
          nx.pp[i] = smul($signed(nx.dq), 36'($signed(nx.kv[i])));
          nx.p3[i] = smul(36'(nx.cy), $signed(nx.cp[i]));
        end
      end

      if (j == ST_TRUNC) begin
        for (int i = 0; i < 3; i++) begin
          nx.proj[i] = 36'(tdiv($signed(nx.pp[i]), 30));
          nx.t3[i]   = 36'(tdiv($signed(nx.p3[i]), 30));
        end
      end

      if (j == ST_MUL_C) begin
        for (int i = 0; i < 3; i++) begin
          nx.p2[i] = smul(36'($signed(nx.omc)), $signed(nx.proj[i]));
        end
      end

      // final sum and saturation
      if (j == ST_OUT) begin
        for (int i = 0; i < 3; i++) begin
          t2  = 40'(tdiv($signed(nx.p2[i]), 29));
          sum = 40'($signed(nx.t1[i])) + t2 + 40'($signed(nx.t3[i]));
          if (sum > SAT_HI) begin
            sum = SAT_HI;
          end else if (sum < SAT_LO) begin
            sum = SAT_LO;
          end
          nx.res[i] = sum[31:0] & MASK;
        end
      end
    end

    assign pipe_d[j] = nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < NST; j++) begin
        pipe_q[j] <= pipe_d[j];
      end
    end
  end

endmodule
`default_nettype wire
